FILE: rtl/gpio_ic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_ic_pkg
// Shared types and constants of the GPIO interrupt controller.
// ----------------------------------------------------------------------------
package gpio_ic_pkg;

  localparam int GROUPS         = 7;
  localparam int PINS_PER_GROUP = 32;

  // fixed field widths
  localparam int MODE_W  = 2;
  localparam int GROUP_W = 3;
  localparam int SEL_W   = 2;
  localparam int DATA_W  = 32;
  localparam int IRQ_W   = 7;

  localparam logic [DATA_W-1:0] PIN_MASK =
    DATA_W'((64'd1 << PINS_PER_GROUP) - 64'd1);

  // transaction kinds
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;

  // register indexes within a group
  localparam logic [SEL_W-1:0] SEL_TYPE     = 2'd0;
  localparam logic [SEL_W-1:0] SEL_POLARITY = 2'd1;
  localparam logic [SEL_W-1:0] SEL_ENABLE   = 2'd2;
  localparam logic [SEL_W-1:0] SEL_STATUS   = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [GROUP_W-1:0] group;
    logic [SEL_W-1:0]   register_select;
    logic [DATA_W-1:0]  write_data;
    logic [DATA_W-1:0]  pin_levels;
  } req_t;

endpackage

FILE: rtl/gpio_ic_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_ic_cmd_if
// Command channel: register read/write or pin sample, valid/ready.
// ----------------------------------------------------------------------------
interface gpio_ic_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [gpio_ic_pkg::MODE_W-1:0]     mode;
  logic [gpio_ic_pkg::GROUP_W-1:0]    group;
  logic [gpio_ic_pkg::SEL_W-1:0]      register_select;
  logic [gpio_ic_pkg::DATA_W-1:0]     write_data;
  logic [gpio_ic_pkg::DATA_W-1:0]     pin_levels;

  modport source (output valid, mode, group, register_select, write_data, pin_levels,
                  input ready);
  modport sink   (input valid, mode, group, register_select, write_data, pin_levels,
                  output ready);
endinterface

FILE: rtl/gpio_ic_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_ic_result_if
// Result channel: read data and per-group interrupt lines, valid/ready.
// ----------------------------------------------------------------------------
interface gpio_ic_result_if;
  logic                            valid;
  logic                            ready;
  logic [gpio_ic_pkg::DATA_W-1:0]  read_data;
  logic [gpio_ic_pkg::IRQ_W-1:0]   group_irq;

  modport source (output valid, read_data, group_irq, input ready);
  modport sink   (input valid, read_data, group_irq, output ready);
endinterface

FILE: rtl/gpio_ic_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_ic_regfile
// Per-group trigger/polarity/enable/status registers, edge/level detection
// and interrupt line generation. State updates when go is high.
// ----------------------------------------------------------------------------
module gpio_ic_regfile (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  gpio_ic_pkg::req_t              req,
  output logic [gpio_ic_pkg::DATA_W-1:0] read_data,
  output logic [gpio_ic_pkg::IRQ_W-1:0]  group_irq
);

  logic [gpio_ic_pkg::DATA_W-1:0] trig_type [gpio_ic_pkg::GROUPS];
  logic [gpio_ic_pkg::DATA_W-1:0] trig_pol  [gpio_ic_pkg::GROUPS];
  logic [gpio_ic_pkg::DATA_W-1:0] irq_en    [gpio_ic_pkg::GROUPS];
  logic [gpio_ic_pkg::DATA_W-1:0] irq_stat  [gpio_ic_pkg::GROUPS];
  logic [gpio_ic_pkg::DATA_W-1:0] prev_pins [gpio_ic_pkg::GROUPS];

  logic [gpio_ic_pkg::DATA_W-1:0] trig_type_next [gpio_ic_pkg::GROUPS];
  logic [gpio_ic_pkg::DATA_W-1:0] trig_pol_next  [gpio_ic_pkg::GROUPS];
  logic [gpio_ic_pkg::DATA_W-1:0] irq_en_next    [gpio_ic_pkg::GROUPS];
  logic [gpio_ic_pkg::DATA_W-1:0] irq_stat_next  [gpio_ic_pkg::GROUPS];
  logic [gpio_ic_pkg::DATA_W-1:0] prev_pins_next [gpio_ic_pkg::GROUPS];

  logic [gpio_ic_pkg::DATA_W-1:0] wdata;
  logic [gpio_ic_pkg::DATA_W-1:0] pins;

  assign wdata = req.write_data & gpio_ic_pkg::PIN_MASK;
  assign pins  = req.pin_levels & gpio_ic_pkg::PIN_MASK;

  always_comb begin
    logic                           hit_grp;
    logic [gpio_ic_pkg::DATA_W-1:0] rising;
    logic [gpio_ic_pkg::DATA_W-1:0] falling;
    logic [gpio_ic_pkg::DATA_W-1:0] edge_hit;
    logic [gpio_ic_pkg::DATA_W-1:0] level_hit;
    logic [gpio_ic_pkg::DATA_W-1:0] hit;
    read_data = '0;
    group_irq = '0;
    for (int g = 0; g < gpio_ic_pkg::GROUPS; g++) begin
      hit_grp   = (req.group == gpio_ic_pkg::GROUP_W'(g));
      rising    = pins & ~prev_pins[g];
      falling   = prev_pins[g] & ~pins;
      edge_hit  = (rising & trig_pol[g]) | (falling & ~trig_pol[g]);
      level_hit = ~(pins ^ trig_pol[g]);
      hit       = (edge_hit & ~trig_type[g]) | (level_hit & trig_type[g]);

      trig_type_next[g] = trig_type[g];
      trig_pol_next[g]  = trig_pol[g];
      irq_en_next[g]    = irq_en[g];
      irq_stat_next[g]  = irq_stat[g];
      prev_pins_next[g] = prev_pins[g];

      if (hit_grp) begin
        case (req.mode)
          gpio_ic_pkg::MODE_READ: begin
            unique case (req.register_select)
              gpio_ic_pkg::SEL_TYPE:     read_data = trig_type[g];
              gpio_ic_pkg::SEL_POLARITY: read_data = trig_pol[g];
              gpio_ic_pkg::SEL_ENABLE:   read_data = irq_en[g];
              default:                   read_data = irq_stat[g];
            endcase
          end
          gpio_ic_pkg::MODE_WRITE: begin
            unique case (req.register_select)
              gpio_ic_pkg::SEL_TYPE:     trig_type_next[g] = wdata;
              gpio_ic_pkg::SEL_POLARITY: trig_pol_next[g]  = wdata;
              gpio_ic_pkg::SEL_ENABLE:   irq_en_next[g]    = wdata;
              default:                   irq_stat_next[g]  = irq_stat[g] & ~wdata;
            endcase
          end
          gpio_ic_pkg::MODE_SAMPLE: begin
            irq_stat_next[g]  = (irq_stat[g] | hit) & gpio_ic_pkg::PIN_MASK;
            prev_pins_next[g] = pins;
          end
          default: ;
        endcase
      end

      // interrupt lines reflect the state after this transaction
      group_irq[g] = |(irq_stat_next[g] & irq_en_next[g]);
    end
    read_data = read_data & gpio_ic_pkg::PIN_MASK;
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < gpio_ic_pkg::GROUPS; g++) begin
      if (rst) begin
        trig_type[g] <= '0;
        trig_pol[g]  <= '0;
        irq_en[g]    <= '0;
        irq_stat[g]  <= '0;
        prev_pins[g] <= '0;
      end else if (go) begin
        trig_type[g] <= trig_type_next[g];
        trig_pol[g]  <= trig_pol_next[g];
        irq_en[g]    <= irq_en_next[g];
        irq_stat[g]  <= irq_stat_next[g];
        prev_pins[g] <= prev_pins_next[g];
      end
    end
  end

  // a read never changes status
  assert property (@(posedge clk) disable iff (rst)
    go && req.mode == gpio_ic_pkg::MODE_READ && req.group == '0
    |=> irq_stat[0] == $past(irq_stat[0]))
    else $error("status changed on a read");

  // a status write can only clear bits
  assert property (@(posedge clk) disable iff (rst)
    go && req.mode == gpio_ic_pkg::MODE_WRITE && req.group == '0
    |=> (irq_stat[0] & ~$past(irq_stat[0])) == '0)
    else $error("status bit set by a write");

  // nothing changes while stalled
  assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(irq_stat[0]) && $stable(prev_pins[0]))
    else $error("state changed without a transaction");

endmodule

FILE: rtl/gpio_interrupt_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_interrupt_controller
// GPIO edge/level interrupt controller: register access and pin sampling
// for 32-pin groups, with one interrupt line per group.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  cmd      in   valid/ready  mode, group, register_select, write_data,
//                             pin_levels
//  result   out  valid/ready  read_data, group_irq
//
//  One transaction per cycle sustained while result.ready stays high; a cmd
//  passes the input register, then the result register, to result valid.
//  Register state updates as the result register loads, so back-to-back
//  transactions see each other's effects in order.
//  Synchronous reset clears all group registers and both pipeline stages.
//  A stalled result holds the input stage; cmd.ready drops only when both
//  stages are full and result.ready is low.
// ----------------------------------------------------------------------------
module gpio_interrupt_controller (
  input  logic                    clk,
  input  logic                    rst,
  gpio_ic_cmd_if.sink             cmd,
  gpio_ic_result_if.source        result
);

  logic                           s1_valid;
  gpio_ic_pkg::req_t              s1_req;
  logic                           out_valid;
  logic [gpio_ic_pkg::DATA_W-1:0] out_data;
  logic [gpio_ic_pkg::IRQ_W-1:0]  out_irq;
  logic                           advance;
  logic [gpio_ic_pkg::DATA_W-1:0] rf_rdata;
  logic [gpio_ic_pkg::IRQ_W-1:0]  rf_irq;

  assign advance   = s1_valid && (!out_valid || result.ready);
  assign cmd.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_req.mode            <= cmd.mode;
      s1_req.group           <= cmd.group;
      s1_req.register_select <= cmd.register_select;
      s1_req.write_data      <= cmd.write_data;
      s1_req.pin_levels      <= cmd.pin_levels;
    end
  end

  gpio_ic_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .req       (s1_req),
    .read_data (rf_rdata),
    .group_irq (rf_irq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= rf_rdata;
      out_irq  <= rf_irq;
    end
  end

  assign result.valid     = out_valid;
  assign result.read_data = out_data;
  assign result.group_irq = out_irq;

  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after stage advance");

  assert property (@(posedge clk) disable iff (rst)
    advance && s1_req.mode != gpio_ic_pkg::MODE_READ |=> result.read_data == '0)
    else $error("nonzero read data on a non-read transaction");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !result.ready |=> s1_valid && $stable(s1_req))
    else $error("input stage moved during result stall");

  assert property (@(posedge clk)
    rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

endmodule
